// File: sv/wrs_pkg.sv
// shared constants, codes and word types for the weighted random select block
package wrs_pkg;

   localparam int MAX_ENTRIES = 64;
   localparam int WEIGHT_BITS = 16;
   localparam int DRAW_BITS   = 16;

   localparam int ID_W    = 16;
   localparam int FIELD_W = 16;
   localparam int IDX_W   = $clog2(MAX_ENTRIES);
   localparam int COUNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int SUM_W   = WEIGHT_BITS + IDX_W;
   localparam int PROD_W  = SUM_W + DRAW_BITS;
   localparam int ENTRY_W = SUM_W + ID_W;

   localparam logic OP_APPEND = 1'b0;
   localparam logic OP_PICK   = 1'b1;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;
   localparam logic [1:0] ST_ZERO  = 2'd3;

   typedef struct packed {
      logic               operation;
      logic [ID_W-1:0]    entry_id;
      logic [FIELD_W-1:0] weight;
      logic [FIELD_W-1:0] random_draw;
   } req_word_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [ID_W-1:0]    picked_id;
      logic [COUNT_W-1:0] entry_count;
   } rsp_word_type;

   typedef struct packed {
      logic [SUM_W-1:0] running_sum;
      logic [ID_W-1:0]  entry_id;
   } entry_type;

endpackage

// File: sv/wrs_ram.sv
// generic single write port, single read port ram with registered read data
module wrs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/weighted_random_select.sv
// Weighted random select: a table of ids with running weight sums, picked by a uniform draw.
// A request word either appends an entry (id, weight) or picks an entry using random_draw.
// Every request word gives exactly one response word: status, picked_id and entry_count.
// An append writes the table in the cycle it is accepted; its response is valid on the
// next cycle. A pick multiplies the draw by the total weight once, then runs a binary
// search over the running sums held in one table ram; each search step passes S_SRCH then S_CMP
// because the ram read data is registered, then one more read fetches the id.
// A pick on an empty table answers on the next cycle without a search, as do rejected appends.
// The next request is taken in the cycle the response word leaves, so appends and rejected
// words run one per cycle while rsp_ready is high; a pick holds the input for its latency.
// The block works on one request at a time: req_ready is low while a pick is in search
// and while a response word waits that the receiver has not taken.
// A stalled response holds in the output register; it is released when rsp_ready is high,
// and a new request may be accepted in that same cycle.
// Synchronous reset empties the table (count and total cleared) and drops any pending
// response; the table ram itself is not cleared, entries are only read below the count.
module weighted_random_select
   import wrs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_word
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_MUL   = 3'd1;
   localparam logic [2:0] S_SRCH  = 3'd2;
   localparam logic [2:0] S_CMP   = 3'd3;
   localparam logic [2:0] S_FETCH = 3'd4;

   logic [2:0]         state_ff, state_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [SUM_W-1:0]   total_ff, total_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [SUM_W-1:0]   thr_ff, thr_in;
   logic [IDX_W-1:0]   lo_ff, lo_in;
   logic [IDX_W-1:0]   hi_ff, hi_in;
   logic [IDX_W-1:0]   mid_ff, mid_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_word_type       rsp_word_ff, rsp_word_in;

   logic                  accept;
   logic [WEIGHT_BITS-1:0] weight;
   logic [DRAW_BITS-1:0]  draw;
   logic [SUM_W-1:0]      new_sum;
   logic [COUNT_W-1:0]    last_idx;
   logic [IDX_W:0]        mid_sum;
   logic [IDX_W-1:0]      mid;
   logic [SUM_W:0]        thr_full;
   logic                  wr_en;
   entry_type             wr_entry;
   entry_type             rd_entry;
   logic [ENTRY_W-1:0]    rd_data;
   logic [IDX_W-1:0]      rd_addr;

   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign weight    = req_word.weight[WEIGHT_BITS-1:0];
   assign draw      = req_word.random_draw[DRAW_BITS-1:0];
   assign new_sum   = total_ff + SUM_W'(weight);
   assign last_idx  = count_ff - 1'b1;
   assign mid_sum   = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid       = mid_sum[IDX_W:1];
   // ceil of draw * total / 2^DRAW_BITS, never above total
   assign thr_full  = {1'b0, prod_ff[PROD_W-1:DRAW_BITS]}
                      + (SUM_W+1)'(|prod_ff[DRAW_BITS-1:0]);
   assign rd_addr   = (lo_ff == hi_ff) ? lo_ff : mid;
   assign rd_entry  = entry_type'(rd_data);

   assign wr_entry.running_sum = new_sum;
   assign wr_entry.entry_id    = req_word.entry_id;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      total_in     = total_ff;
      prod_in      = prod_ff;
      thr_in       = thr_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_word_in  = rsp_word_ff;
      wr_en        = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_word_in.picked_id   = '0;
               rsp_word_in.entry_count = count_ff;
               rsp_word_in.status      = ST_OK;
               if (req_word.operation == OP_APPEND) begin
                  rsp_valid_in = 1'b1;
                  priority if (weight == '0) begin
                     rsp_word_in.status = ST_ZERO;
                  end else if (count_ff == COUNT_W'(MAX_ENTRIES)) begin
                     rsp_word_in.status = ST_FULL;
                  end else begin
                     wr_en                   = 1'b1;
                     total_in                = new_sum;
                     count_in                = count_ff + 1'b1;
                     rsp_word_in.entry_count = count_ff + 1'b1;
                  end
               end else if (count_ff == '0) begin
                  rsp_valid_in       = 1'b1;
                  rsp_word_in.status = ST_EMPTY;
               end else begin
                  prod_in  = PROD_W'(draw) * PROD_W'(total_ff);
                  lo_in    = '0;
                  hi_in    = last_idx[IDX_W-1:0];
                  state_in = S_MUL;
               end
            end
         end
         S_MUL: begin
            thr_in   = thr_full[SUM_W-1:0];
            state_in = S_SRCH;
         end
         S_SRCH: begin
            // ram address is driven from lo/hi this cycle
            mid_in = mid;
            if (lo_ff == hi_ff) begin
               state_in = S_FETCH;
            end else begin
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            if (rd_entry.running_sum >= thr_ff) begin
               hi_in = mid_ff;
            end else begin
               lo_in = mid_ff + 1'b1;
            end
            state_in = S_SRCH;
         end
         S_FETCH: begin
            rsp_valid_in          = 1'b1;
            rsp_word_in.status    = ST_OK;
            rsp_word_in.picked_id = rd_entry.entry_id;
            state_in              = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      prod_ff     <= prod_in;
      thr_ff      <= thr_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      mid_ff      <= mid_in;
      rsp_word_ff <= rsp_word_in;
   end

   wrs_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (wr_entry),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule
